### rtl/lrut_pkg.sv
// Shared constants and types for the LRU replacement tracker.
// No dependencies; imported by the channel interfaces, the cell and the top level.
package lrut_pkg;

  // Fixed field widths of the transaction payloads
  localparam int KEY_IN_W = 8;
  localparam int CFG_W    = 5;
  localparam int RES_W    = 5;

  // Default sizing handed to the top level
  localparam int MAX_FRAMES_DEF = 16;
  localparam int KEY_SPACE_DEF  = 256;

  // Register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_FRAMES = 3'd0;
  localparam logic [CFG_W-1:0]   FRAMES_RST  = 5'd16;

  // Per-reference control broadcast along the cell row
  typedef struct packed {
    logic load;  // a reference is taken this cycle
    logic hit;   // the reference matched a resident key
  } cell_ctl_t;

endpackage

### rtl/lrut_ifs.sv
// Valid/ready channel interfaces for references and results of the tracker.
// Depends on lrut_pkg for the payload widths.
interface lrut_in_if;
  import lrut_pkg::*;

  logic                valid;
  logic                ready;
  logic [KEY_IN_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface lrut_out_if;
  import lrut_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic                evicted_valid;
  logic [KEY_IN_W-1:0] evicted_key;
  logic [RES_W-1:0]    resident_after;

  modport source (output valid, output hit, output evicted_valid, output evicted_key,
                  output resident_after, input ready);
  modport sink   (input valid, input hit, input evicted_valid, input evicted_key,
                  input resident_after, output ready);
endinterface

### rtl/lrut_cell.sv
// One slot of the recency stack: holds a key and its valid bit, matches it
// against the reference and takes its neighbour's entry when the stack shifts.
// Depends on lrut_pkg for cell_ctl_t.
module lrut_cell #(
  parameter int IDX   = 0,
  parameter int KEY_W = 8,
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lrut_pkg::cell_ctl_t  ctl,
  input  logic [IDX_W-1:0]     upto,
  input  logic [KEY_W-1:0]     match_key,
  input  logic [KEY_W-1:0]     nb_key,
  input  logic                 nb_valid,
  input  logic                 chain_in,
  output logic                 chain_out,
  output logic [KEY_W-1:0]     key_q,
  output logic                 valid_q
);
  import lrut_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic             valid_r;
  logic             match;
  logic             shift;

  // Match this slot and pass "a match at or above here" down the row
  assign match     = valid_r && (key_r == match_key);
  assign chain_out = match || chain_in;

  // Slot 0 always takes the new key; others shift up to the hit slot,
  // or up to the insertion limit on a miss
  generate
    if (IDX == 0) begin : g_head
      assign shift = ctl.load;
    end else begin : g_body
      assign shift = ctl.load && (ctl.hit ? chain_out : (IDX_W'(IDX) <= upto));
    end
  endgenerate

  // Hold or take the neighbour's entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_r <= nb_key;
    end
  end

  assign key_q   = key_r;
  assign valid_q = valid_r;

endmodule

### rtl/lru_replacement_tracker.sv
// Fully associative LRU replacement tracker built as a row of recency cells.
// Result of an accepted reference is offered in the next cycle, from an output register.
// Throughput: one reference per cycle unless the result is stalled; match, eviction and
// the stack shift all complete in the accept cycle across the cell row.
// Reset (synchronous, rst_n low): all slots invalid, resident count zero,
// frame limit 16, no result pending.
module lru_replacement_tracker #(
  parameter int MAX_FRAMES = lrut_pkg::MAX_FRAMES_DEF,
  parameter int KEY_SPACE  = lrut_pkg::KEY_SPACE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lrut_in_if.sink                       in_ch,
  lrut_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrut_pkg::PADDR_W-1:0]  paddr,
  input  logic [lrut_pkg::PDATA_W-1:0]  pwdata,
  output logic [lrut_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import lrut_pkg::*;

  localparam int IDX_W  = $clog2(MAX_FRAMES);
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int KS_W   = $clog2(KEY_SPACE);
  localparam int KEY_W  = (KS_W < KEY_IN_W) ? KS_W : KEY_IN_W;
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RED_W  = 16;
  localparam logic [RED_W-1:0] KS_C  = RED_W'(KEY_SPACE);
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_FRAMES);

  // Configuration register
  logic [CFG_W-1:0] frames_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= FRAMES_RST;
    end else if (psel && penable && pwrite && (paddr == ADDR_FRAMES)) begin
      frames_r <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_FRAMES) begin
      prdata = PDATA_W'(frames_r);
    end
  end

  // Channel handshake: take a reference while the output register is free or draining
  logic out_valid_r;
  logic accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Reduce the key into the key space by restoring subtraction
  logic [RED_W-1:0] red;
  logic [KEY_W-1:0] key_k;

  always_comb begin
    red = RED_W'(in_ch.key);
    for (int j = 3; j >= 0; j--) begin
      if (red >= (KS_C << j)) begin
        red = red - (KS_C << j);
      end
    end
    key_k = red[KEY_W-1:0];
  end

  // Resident count and frame limit
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] count_ext;
  logic             evict;
  logic [CNT_W-1:0] count_m;
  logic [IDX_W-1:0] upto;
  logic [IDX_W-1:0] last_idx;

  always_comb begin
    limit = CMP_W'(frames_r);
    if (frames_r == '0) begin
      limit = CMP_W'(1);
    end else if (limit > MAX_C) begin
      limit = MAX_C;
    end
  end

  assign count_ext = CMP_W'(count_r);
  assign evict     = (count_ext >= limit) && (count_r != '0);
  assign count_m   = evict ? (count_r - CNT_W'(1)) : count_r;
  assign upto      = (count_m >= CNT_W'(MAX_FRAMES - 1)) ? IDX_W'(MAX_FRAMES - 1)
                                                         : count_m[IDX_W-1:0];
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));

  // Cell row
  logic [MAX_FRAMES:0] chain;
  logic [KEY_W-1:0]    cell_key   [MAX_FRAMES];
  logic                cell_valid [MAX_FRAMES];
  cell_ctl_t           ctl;
  logic                hit;

  assign chain[MAX_FRAMES] = 1'b0;
  assign hit               = chain[0];
  assign ctl.load          = accept;
  assign ctl.hit           = hit;

  generate
    for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      logic [KEY_W-1:0] nb_key;
      logic             nb_valid;
      if (i == 0) begin : g_src_new
        assign nb_key   = key_k;
        assign nb_valid = 1'b1;
      end else begin : g_src_nb
        assign nb_key   = cell_key[i-1];
        assign nb_valid = cell_valid[i-1];
      end
      lrut_cell #(
        .IDX   (i),
        .KEY_W (KEY_W),
        .IDX_W (IDX_W)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .upto      (upto),
        .match_key (key_k),
        .nb_key    (nb_key),
        .nb_valid  (nb_valid),
        .chain_in  (chain[i+1]),
        .chain_out (chain[i]),
        .key_q     (cell_key[i]),
        .valid_q   (cell_valid[i])
      );
    end
  endgenerate

  // Advance the resident count
  assign count_nxt = hit ? count_r : (CNT_W'(upto) + CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Result register
  logic                hit_r;
  logic                ev_valid_r;
  logic [KEY_IN_W-1:0] ev_key_r;
  logic [RES_W-1:0]    res_after_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r       <= hit;
      ev_valid_r  <= !hit && evict;
      ev_key_r    <= (!hit && evict) ? KEY_IN_W'(cell_key[last_idx]) : '0;
      res_after_r <= RES_W'(count_nxt);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit            = hit_r;
  assign out_ch.evicted_valid  = ev_valid_r;
  assign out_ch.evicted_key    = ev_key_r;
  assign out_ch.resident_after = res_after_r;

endmodule
